### rtl/core/multichannel_biquad_filter_top_defines.svh
// Assertion macros used by the filter pipeline.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef MULTICHANNEL_BIQUAD_FILTER_TOP_DEFINES_SVH
`define MULTICHANNEL_BIQUAD_FILTER_TOP_DEFINES_SVH

// Check a property outside reset.
`define MBQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check a property at every edge, reset included.
`define MBQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

### rtl/core/mbq_pkg.sv
`default_nettype none

package mbq_pkg;

	// Channel store depth and sizes
	localparam int CHANNELS = 64;
	localparam int CH_W     = 6;
	localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Sample and coefficient formats (coefficients are Q2.18)
	localparam int SAMPLE_W = 24;
	localparam int COEF_W   = 20;
	localparam int FRAC_W   = 18;
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	localparam int ACC_W    = PROD_W + 3;
	localparam int RND_W    = ACC_W - FRAC_W;

	// Configuration registers
	localparam int NUM_W     = 3 * COEF_W;
	localparam int DEN_W     = 2 * COEF_W;
	localparam int CFG_W     = NUM_W;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_TIP_NUM  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TIP_DEN  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BASE_NUM = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BASE_DEN = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SPLIT    = 3'd4;

	localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(262144);
	localparam logic [DEN_W-1:0] DEN_RESET = '0;

	typedef struct packed {
		logic [CH_W-1:0]            channel;
		logic signed [SAMPLE_W-1:0] sample_in;
	} in_word_t;

	typedef struct packed {
		logic [CH_W-1:0]            channel_out;
		logic signed [SAMPLE_W-1:0] sample_out;
	} out_word_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_set_t;

	typedef struct packed {
		coef_set_t tip;
		coef_set_t base;
		logic      axis_split;
	} cfg_t;

	// Per-channel history held in the state memory
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x1;
		logic signed [SAMPLE_W-1:0] x2;
		logic signed [SAMPLE_W-1:0] y1;
		logic signed [SAMPLE_W-1:0] y2;
	} hist_t;

	localparam int HIST_W = $bits(hist_t);

	typedef struct packed {
		logic             re;
		logic [CH_AW-1:0] raddr;
		logic             we;
		logic [CH_AW-1:0] waddr;
		hist_t            wdata;
	} mem_req_t;

endpackage

`default_nettype wire

### rtl/core/mbq_ram.sv
`default_nettype none

module mbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port; registered read returns old data on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/mbq_cfg.sv
`default_nettype none

module mbq_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mbq_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [mbq_pkg::CFG_W-1:0]     cfg_wdata,
	output mbq_pkg::cfg_t                      cfg
);

	import mbq_pkg::*;

	logic [NUM_W-1:0] tip_num_q;
	logic [DEN_W-1:0] tip_den_q;
	logic [NUM_W-1:0] base_num_q;
	logic [DEN_W-1:0] base_den_q;
	logic             split_q;

	// Take register writes; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tip_num_q  <= NUM_RESET;
			tip_den_q  <= DEN_RESET;
			base_num_q <= NUM_RESET;
			base_den_q <= DEN_RESET;
			split_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIP_NUM:  tip_num_q  <= cfg_wdata[NUM_W-1:0];
				REG_TIP_DEN:  tip_den_q  <= cfg_wdata[DEN_W-1:0];
				REG_BASE_NUM: base_num_q <= cfg_wdata[NUM_W-1:0];
				REG_BASE_DEN: base_den_q <= cfg_wdata[DEN_W-1:0];
				REG_SPLIT:    split_q    <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Unpack the Q2.18 slices
	assign cfg.tip.b0  = $signed(tip_num_q[COEF_W-1:0]);
	assign cfg.tip.b1  = $signed(tip_num_q[2*COEF_W-1:COEF_W]);
	assign cfg.tip.b2  = $signed(tip_num_q[3*COEF_W-1:2*COEF_W]);
	assign cfg.tip.a1  = $signed(tip_den_q[COEF_W-1:0]);
	assign cfg.tip.a2  = $signed(tip_den_q[2*COEF_W-1:COEF_W]);
	assign cfg.base.b0 = $signed(base_num_q[COEF_W-1:0]);
	assign cfg.base.b1 = $signed(base_num_q[2*COEF_W-1:COEF_W]);
	assign cfg.base.b2 = $signed(base_num_q[3*COEF_W-1:2*COEF_W]);
	assign cfg.base.a1 = $signed(base_den_q[COEF_W-1:0]);
	assign cfg.base.a2 = $signed(base_den_q[2*COEF_W-1:COEF_W]);
	assign cfg.axis_split = split_q;

endmodule

`default_nettype wire

### rtl/core/mbq_pipe.sv
`default_nettype none
`include "multichannel_biquad_filter_top_defines.svh"

module mbq_pipe (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mbq_pkg::cfg_t       cfg,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire mbq_pkg::in_word_t   item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output mbq_pkg::out_word_t       result,
	output mbq_pkg::mem_req_t        mem,
	input  wire mbq_pkg::hist_t      mem_rdata
);

	import mbq_pkg::*;

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// Clearing pass
	logic             clearing_q;
	logic [CH_AW-1:0] clr_addr_q;

	// Stage 1: history arrives, multiply
	logic                       valid_s1;
	logic [CH_W-1:0]            ch_s1;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic                       live_s1;

	// Stage 2: sum, round, saturate, write back
	logic                       valid_s2;
	logic [CH_W-1:0]            ch_s2;
	logic                       live_s2;
	logic signed [SAMPLE_W-1:0] x_s2;
	logic signed [SAMPLE_W-1:0] x1_s2;
	logic signed [SAMPLE_W-1:0] y1_s2;
	logic signed [PROD_W-1:0]   prod_s2 [5];

	// Output register
	logic      result_valid_q;
	out_word_t result_q;

	// Last write back, forwarded over the memory read
	logic             wb_valid_q;
	logic [CH_AW-1:0] wb_addr_q;
	hist_t            wb_hist_q;

	logic                       out_free;
	logic                       mv_s2;
	logic                       s2_free;
	logic                       mv_s1;
	logic                       s1_free;
	logic                       hazard;
	logic                       accept;
	logic                       live_in;
	logic                       tip_s1;
	coef_set_t                  coef;
	hist_t                      hist;
	logic signed [PROD_W-1:0]   prod [5];
	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-1:0]    acc_rnd;
	logic signed [RND_W-1:0]    y_rnd;
	logic signed [SAMPLE_W-1:0] y_sat;
	logic signed [SAMPLE_W-1:0] y_s2;
	hist_t                      hist_new;

	// Advance each stage when the next one is empty or moving
	assign out_free = !result_valid_q || result_ready;
	assign mv_s2    = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || mv_s2;
	assign mv_s1    = valid_s1 && s2_free;
	assign s1_free  = !valid_s1 || mv_s1;

	// Hold a word whose channel is still ahead of its write back
	assign hazard = (valid_s1 && ch_s1 == item.channel)
		|| (valid_s2 && !mv_s2 && ch_s2 == item.channel);

	assign item_ready = !clearing_q && s1_free && !hazard;
	assign accept     = item_valid && item_ready;
	assign live_in    = (int'(item.channel) < CHANNELS);

	// Sweep zeros through the state memory after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == CH_AW'(CHANNELS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1   <= item.channel;
			x_s1    <= item.sample_in;
			live_s1 <= live_in;
		end
	end

	// Pick the coefficient set and the freshest history
	assign tip_s1 = cfg.axis_split && ch_s1 == '0;
	assign coef   = tip_s1 ? cfg.tip : cfg.base;
	assign hist   = (wb_valid_q && wb_addr_q == CH_AW'(ch_s1)) ? wb_hist_q : mem_rdata;

	assign prod[0] = coef.b0 * x_s1;
	assign prod[1] = coef.b1 * hist.x1;
	assign prod[2] = coef.b2 * hist.x2;
	assign prod[3] = coef.a1 * hist.y1;
	assign prod[4] = coef.a2 * hist.y2;

	// Stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= mv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s1) begin
			ch_s2   <= ch_s1;
			live_s2 <= live_s1;
			x_s2    <= x_s1;
			x1_s2   <= hist.x1;
			y1_s2   <= hist.y1;
			for (int i = 0; i < 5; i++) begin
				prod_s2[i] <= prod[i];
			end
		end
	end

	// Sum, round half up, saturate
	assign acc = ACC_W'(prod_s2[0]) + ACC_W'(prod_s2[1]) + ACC_W'(prod_s2[2])
		- ACC_W'(prod_s2[3]) - ACC_W'(prod_s2[4]);
	assign acc_rnd = acc + ACC_W'(2 ** (FRAC_W - 1));
	assign y_rnd   = acc_rnd[ACC_W-1:FRAC_W];

	always_comb begin
		if (y_rnd > RND_W'(SAT_MAX)) begin
			y_sat = SAT_MAX;
		end else if (y_rnd < RND_W'(SAT_MIN)) begin
			y_sat = SAT_MIN;
		end else begin
			y_sat = y_rnd[SAMPLE_W-1:0];
		end
	end

	assign y_s2 = live_s2 ? y_sat : '0;

	// Shift the history for write back
	assign hist_new.x1 = x_s2;
	assign hist_new.x2 = x1_s2;
	assign hist_new.y1 = y_sat;
	assign hist_new.y2 = y1_s2;

	// Memory port: read on accept, write back or clear
	assign mem.re    = accept;
	assign mem.raddr = CH_AW'(item.channel);
	assign mem.we    = clearing_q || (mv_s2 && live_s2);
	assign mem.waddr = clearing_q ? clr_addr_q : CH_AW'(ch_s2);
	assign mem.wdata = clearing_q ? hist_t'('0) : hist_new;

	// Keep the last write back for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_valid_q <= 1'b0;
		end else if (mv_s2 && live_s2) begin
			wb_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s2 && live_s2) begin
			wb_addr_q <= CH_AW'(ch_s2);
			wb_hist_q <= hist_new;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (mv_s2) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s2) begin
			result_q.channel_out <= ch_s2;
			result_q.sample_out  <= y_s2;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Assertions
	`MBQ_ASSERT(a_no_same_channel_in_flight, (valid_s1 && valid_s2) |-> (ch_s1 != ch_s2), "same channel in stage 1 and stage 2")
	`MBQ_ASSERT_ALWAYS(a_clear_writes_zero, (mem.we && clearing_q) |-> (mem.wdata == '0), "clearing pass wrote nonzero history")
	`MBQ_ASSERT(a_accept_fills_s1, accept |=> valid_s1, "accepted word did not reach stage 1")
	`MBQ_ASSERT(a_clear_runs_once, !clearing_q |=> !clearing_q, "clearing pass restarted")
	`MBQ_ASSERT(a_result_from_s2, $rose(result_valid_q) |-> $past(valid_s2), "result without stage 2 word")

endmodule

`default_nettype wire

### rtl/core/multichannel_biquad_filter_top.sv
`default_nettype none

// Multichannel Direct Form I biquad. Each item word carries a channel index and a 24-bit
// sample; the result word echoes the channel with the filtered sample, rounded half up and
// saturated to 24 bits. Per-channel history (two past inputs, two past outputs) lives in one
// single-port-write, registered-read memory of CHANNELS entries. After reset a clearing pass
// writes zeros to every entry, one per cycle, with item_ready low; configuration writes are
// taken throughout. The block takes one word per cycle as long as consecutive words belong
// to different channels and the output is not stalled; a word for the same channel as the
// word just before it waits until that word leaves stage 1, since the new history comes out
// of the two-stage multiply and sum loop and is forwarded from the write-back register. A
// result passes stage 1 and stage 2 into the output register. Channel 0 uses the tip
// coefficient set while axis_split is 1; all other channels use the base set.
module multichannel_biquad_filter_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mbq_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [mbq_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire mbq_pkg::in_word_t             item,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output mbq_pkg::out_word_t                 result
);

	import mbq_pkg::*;

	cfg_t     cfg;
	mem_req_t mem;
	hist_t    mem_rdata;

	// Configuration registers
	mbq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Filter pipeline
	mbq_pipe u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.mem          (mem),
		.mem_rdata    (mem_rdata)
	);

	// Per-channel history memory
	mbq_ram #(
		.WIDTH (HIST_W),
		.DEPTH (CHANNELS)
	) u_hist_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import mbq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 175;
	// indexes past the register list, decoded as nothing
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	in_word_t             item = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	out_word_t            result;

	multichannel_biquad_filter_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Coefficient registers as the filter should hold them
	logic [NUM_W-1:0] tip_num_q = NUM_RESET;
	logic [DEN_W-1:0] tip_den_q = DEN_RESET;
	logic [NUM_W-1:0] base_num_q = NUM_RESET;
	logic [DEN_W-1:0] base_den_q = DEN_RESET;
	logic             split_q = 1'b1;

	// Per-channel history of the filter
	logic signed [SAMPLE_W-1:0] x_prev [CHANNELS] = '{default: '0};
	logic signed [SAMPLE_W-1:0] x_older [CHANNELS] = '{default: '0};
	logic signed [SAMPLE_W-1:0] y_prev [CHANNELS] = '{default: '0};
	logic signed [SAMPLE_W-1:0] y_older [CHANNELS] = '{default: '0};

	out_word_t expected_words [$];
	int        words_sent = 0;
	int        words_checked = 0;
	int        errors = 0;
	int        reported = 0;
	int        cycle_count = 0;
	int        hold_left = 0;
	bit        held_off = 1'b0;

	typedef struct {
		bit                         cfg_row;
		logic [REG_IDX_W-1:0]       idx;
		logic [CFG_W-1:0]           data;
		in_word_t                   w;
		bit                         known;
		logic signed [SAMPLE_W-1:0] want;
	} dir_row_t;

	dir_row_t dir_rows [$];

	// One filter step: pick the coefficient set, sum five products, round, saturate
	function automatic out_word_t biquad_predict(in_word_t w);
		logic [NUM_W-1:0]         num;
		logic [DEN_W-1:0]         den;
		logic signed [COEF_W-1:0] b0, b1, b2, a1, a2;
		longint                   acc;
		longint                   y;
		int                       ch;
		out_word_t                r;
		ch = int'(w.channel);
		y = 0;
		if (ch < CHANNELS) begin
			if (split_q && ch == 0) begin
				num = tip_num_q;
				den = tip_den_q;
			end else begin
				num = base_num_q;
				den = base_den_q;
			end
			b0 = num[19:0];
			b1 = num[39:20];
			b2 = num[59:40];
			a1 = den[19:0];
			a2 = den[39:20];
			acc = longint'(b0) * longint'(w.sample_in) + longint'(b1) * longint'(x_prev[ch])
				+ longint'(b2) * longint'(x_older[ch]) - longint'(a1) * longint'(y_prev[ch])
				- longint'(a2) * longint'(y_older[ch]);
			// round half up, then floor shift
			y = (acc + 131072) >>> FRAC_W;
			if (y > 8388607) y = 8388607;
			if (y < -8388608) y = -8388608;
			x_older[ch] = x_prev[ch];
			x_prev[ch] = w.sample_in;
			y_older[ch] = y_prev[ch];
			y_prev[ch] = y[SAMPLE_W-1:0];
		end
		r.channel_out = w.channel;
		r.sample_out = y[SAMPLE_W-1:0];
		return r;
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef(int unsigned span);
		int v;
		if (span == 0) return COEF_W'($urandom());
		v = int'($urandom_range(2 * span - 1)) - int'(span);
		return v[COEF_W-1:0];
	endfunction

	function automatic void row_word(int ch, int x, bit known, int want);
		dir_row_t r;
		r = '{default: '0};
		r.w.channel = ch[CH_W-1:0];
		r.w.sample_in = x[SAMPLE_W-1:0];
		r.known = known;
		r.want = want[SAMPLE_W-1:0];
		dir_rows.push_back(r);
	endfunction

	function automatic void row_cfg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		dir_row_t r;
		r = '{default: '0};
		r.cfg_row = 1'b1;
		r.idx = idx;
		r.data = data;
		dir_rows.push_back(r);
	endfunction

	// Write one register, then mirror it with the width masking applied
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TIP_NUM: tip_num_q = data;
			REG_TIP_DEN: tip_den_q = data[DEN_W-1:0];
			REG_BASE_NUM: base_num_q = data;
			REG_BASE_DEN: base_den_q = data[DEN_W-1:0];
			REG_SPLIT: split_q = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Offer one word, at times after a random gap, and log its expected result on acceptance
	task automatic push_word(input in_word_t w, input bit known,
			input logic signed [SAMPLE_W-1:0] want);
		out_word_t predicted;
		if (!(words_sent >= 700 && words_sent < 900) && $urandom_range(99) < 32) begin
			if (item_valid) item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 32);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (!item_ready);
		predicted = biquad_predict(w);
		if (known) predicted.sample_out = want;
		expected_words.push_back(predicted);
		words_sent++;
	endtask

	// Drop valid and wait until every result is back
	task automatic wait_drained();
		if (item_valid) item_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	// Result side: check each word, idle at random, hold off once for a long stretch
	always @(posedge clk) begin : check_results
		out_word_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_words.size() == 0) begin
					errors++;
					if (reported < 10) begin
						reported++;
						$display("unexpected word: channel %0d sample %0d",
							result.channel_out, result.sample_out);
					end
				end else begin
					want = expected_words.pop_front();
					words_checked++;
					if (result.channel_out !== want.channel_out
							|| result.sample_out !== want.sample_out) begin
						errors++;
						if (reported < 10) begin
							reported++;
							$display("mismatch: channel %0d/%0d sample %0d/%0d (expected/actual)",
								want.channel_out, result.channel_out,
								want.sample_out, result.sample_out);
						end
					end
				end
			end
			if (!held_off && words_checked >= 300) begin
				held_off = 1'b1;
				hold_left = 300;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (words_checked >= 700 && words_checked < 900) begin
				result_ready <= 1'b1;
			end else begin
				result_ready <= ($urandom_range(99) >= 32);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		in_word_t         w;
		logic [NUM_W-1:0] tip_n, base_n;
		logic [NUM_W-1:0] tip_d, base_d;
		logic [CFG_W-1:0] split_data;
		int unsigned      span_b, span_a;
		int               v;
		int               r;
		logic [CH_W-1:0]  last_ch;

		// identity after reset: output equals input
		row_word(0, 8388607, 1, 8388607);
		row_word(0, -8388608, 1, -8388608);
		row_word(63, 8388607, 1, 8388607);
		row_word(63, -8388608, 1, -8388608);
		row_word(5, 1, 1, 1);
		row_word(5, -1, 1, -1);
		// writes past the register list change nothing
		row_cfg(REG_SPARE_LO, '1);
		row_cfg(REG_SPARE_HI, '1);
		row_word(0, 4242, 1, 4242);
		row_word(5, 0, 1, 0);
		// largest gain saturates both ways; channel 0 still on the tip set
		row_cfg(REG_BASE_NUM, 60'h7FFFF);
		row_word(1, 8388607, 1, 8388607);
		row_word(1, -8388608, 1, -8388608);
		row_word(0, 12345, 1, 12345);
		// split off with masked upper bits: channel 0 moves to the base set
		row_cfg(REG_SPLIT, 60'hFFFFFFFFFFFFFFE);
		row_word(0, 1000, 1, 2000);
		// most negative gain
		row_cfg(REG_BASE_NUM, 60'h80000);
		row_word(2, -8388608, 1, 8388607);
		row_word(2, 8388607, 1, -8388608);
		// smallest gain: rounding ties go up
		row_cfg(REG_BASE_NUM, 60'h1);
		row_word(3, 131072, 1, 1);
		row_word(3, -131072, 1, 0);
		row_word(3, 131071, 1, 0);
		// full feedback on both sets, garbage above the denominator fields
		row_cfg(REG_TIP_NUM, 60'h100002000010000);
		row_cfg(REG_TIP_DEN, 60'hABCDE20000C0000);
		row_cfg(REG_SPLIT, 60'hA5A5A5A5A5A5A51);
		row_cfg(REG_BASE_NUM, 60'hF80003000020000);
		row_cfg(REG_BASE_DEN, 60'h12345F000008000);
		row_word(0, 4000000, 0, 0);
		row_word(0, -3000000, 0, 0);
		row_word(4, 8388607, 0, 0);
		row_word(0, 100, 0, 0);
		row_word(4, -8388608, 0, 0);
		row_word(4, -8388608, 0, 0);
		row_word(0, 0, 0, 0);
		row_word(4, 777777, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg_row) begin
				wait_drained();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				push_word(dir_rows[i].w, dir_rows[i].known, dir_rows[i].want);
			end
		end

		last_ch = '0;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			if (p == 0) begin
				tip_n = {3{20'h7FFFF}};
				base_n = tip_n;
				tip_d = {20'hFFFFF, {2{20'h7FFFF}}};
				base_d = tip_d;
				split_data = 60'h1;
			end else if (p == 1) begin
				tip_n = {3{20'h80000}};
				base_n = tip_n;
				tip_d = {20'h0, {2{20'h80000}}};
				base_d = tip_d;
				split_data = 60'hFFFFFFFFFFFFFFE;
			end else begin
				// even phases draw small coefficients to keep the filters gentle
				span_b = (p % 2 == 0) ? 131072 : 0;
				span_a = (p % 2 == 0) ? 16384 : 0;
				tip_n = {rand_coef(span_b), rand_coef(span_b), rand_coef(span_b)};
				base_n = {rand_coef(span_b), rand_coef(span_b), rand_coef(span_b)};
				tip_d = {rand_coef(0), rand_coef(span_a), rand_coef(span_a)};
				base_d = {rand_coef(0), rand_coef(span_a), rand_coef(span_a)};
				split_data = CFG_W'({$urandom(), $urandom()});
			end
			write_reg(REG_TIP_NUM, tip_n);
			write_reg(REG_TIP_DEN, tip_d);
			write_reg(REG_BASE_NUM, base_n);
			write_reg(REG_BASE_DEN, base_d);
			write_reg(REG_SPLIT, split_data);

			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				// repeat the channel often to hit the back-to-back forwarding path
				r = $urandom_range(99);
				if (r < 25) w.channel = last_ch;
				else if (r < 40) w.channel = '0;
				else w.channel = CH_W'($urandom_range(CHANNELS - 1));
				r = $urandom_range(9);
				if (r == 0) v = 8388607;
				else if (r == 1) v = -8388608;
				else if (r < 5) v = int'($urandom_range(4095)) - 2048;
				else v = int'($urandom_range(16777215)) - 8388608;
				w.sample_in = v[SAMPLE_W-1:0];
				last_ch = w.channel;
				push_word(w, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (expected_words.size() != 0) errors++;

		$display("Filtered %0d samples, %0d checked, over %0d coefficient settings",
			words_sent, words_checked, RANDOM_PHASES + 5);
		$display("Receiver hold-off done: %0d, mismatches: %0d", held_off, errors);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mbq_pkg.sv
rtl/core/mbq_ram.sv
rtl/core/mbq_cfg.sv
rtl/core/mbq_pipe.sv
rtl/core/multichannel_biquad_filter_top.sv
verif/testbench.sv
